[hdl/assert_macros.svh]
// Assertion macros used by the allocator top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check, also evaluated during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/asa_pkg.sv]
// Types, constants and codes for the aligned slot allocator.
package asa_pkg;

  localparam int unsigned REGION_BYTES = 64;
  localparam int unsigned LANES        = 4;
  localparam int unsigned ROWS         = (REGION_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned OFF_W        = ROW_W + 2;

  localparam logic [2:0] SZ_ONE  = 3'd1;
  localparam logic [2:0] SZ_TWO  = 3'd2;
  localparam logic [2:0] SZ_FOUR = 3'd4;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic             hit;
    logic [1:0]       lane;
    logic [LANES-1:0] set_mask;
  } chk_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [LANES-1:0] mask;
  } bm_wr_t;

endpackage

[hdl/asa_bitmap.sv]
// Used-byte bitmap, one row of four bytes per entry, cleared by reset.
module asa_bitmap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [asa_pkg::ROW_W-1:0] rd_row_i,
  output logic [asa_pkg::LANES-1:0] rd_data_o,
  input  asa_pkg::bm_wr_t           wr_i
);

  logic [asa_pkg::LANES-1:0] rows_q [asa_pkg::ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(asa_pkg::ROWS); i++) begin
        rows_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      rows_q[wr_i.row] <= rows_q[wr_i.row] | wr_i.mask;
    end
  end

  assign rd_data_o = rows_q[rd_row_i];

endmodule

[hdl/asa_row_check.sv]
// Shared row checker: finds the lowest aligned free slot within one row.
module asa_row_check (
  input  logic [asa_pkg::ROW_W-1:0] row_i,
  input  logic [asa_pkg::LANES-1:0] used_i,
  input  logic [2:0]                size_i,
  output asa_pkg::chk_t             chk_o
);

  logic [asa_pkg::LANES-1:0] busy;

  always_comb begin
    for (int j = 0; j < int'(asa_pkg::LANES); j++) begin
      busy[j] = used_i[j] |
                ((32'(row_i) * 32'(asa_pkg::LANES) + 32'(j)) >= 32'(asa_pkg::REGION_BYTES));
    end
  end

  always_comb begin
    chk_o = '0;
    case (size_i)
      asa_pkg::SZ_ONE: begin
        if (!busy[0]) begin
          chk_o = '{hit: 1'b1, lane: 2'd0, set_mask: 4'b0001};
        end else if (!busy[1]) begin
          chk_o = '{hit: 1'b1, lane: 2'd1, set_mask: 4'b0010};
        end else if (!busy[2]) begin
          chk_o = '{hit: 1'b1, lane: 2'd2, set_mask: 4'b0100};
        end else if (!busy[3]) begin
          chk_o = '{hit: 1'b1, lane: 2'd3, set_mask: 4'b1000};
        end
      end
      asa_pkg::SZ_TWO: begin
        if (busy[1:0] == 2'b00) begin
          chk_o = '{hit: 1'b1, lane: 2'd0, set_mask: 4'b0011};
        end else if (busy[3:2] == 2'b00) begin
          chk_o = '{hit: 1'b1, lane: 2'd2, set_mask: 4'b1100};
        end
      end
      asa_pkg::SZ_FOUR: begin
        if (busy == 4'b0000) begin
          chk_o = '{hit: 1'b1, lane: 2'd0, set_mask: 4'b1111};
        end
      end
      default: begin
        chk_o = '0;
      end
    endcase
  end

endmodule

[hdl/aligned_slot_allocator.sv]
// Top level of the aligned slot allocator: sequencer, output register, config.
//
//   channel  dir  payload                          handshake
//   s_axis   in   tdata[2:0] request_size          tvalid/tready
//   m_axis   out  tdata slot_address, tuser status tvalid/tready
//   cfg      in   cfg_data_i region_base           cfg_valid_i/cfg_ready_o
//
// One request: the accept, then a scan of up to ROWS (16) rows, one row of
// four bytes per cycle through the shared row checker; an invalid size, the
// first row holding a fitting slot, or the last row ends the scan.
// Reset clears the bitmap flops at once; region_base resets to 0.
// A result waiting on m_axis holds the scan at its final row until taken.
// cfg writes are always taken.
`include "assert_macros.svh"

module aligned_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] request_size
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] slot_address
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  asa_pkg::state_e            state_q, state_d;
  logic [asa_pkg::ROW_W-1:0]  row_q, row_d;
  logic [2:0]                 size_q, size_d;
  logic [31:0]                base_q;
  logic                       out_valid_q, out_valid_d;
  asa_pkg::status_e           out_status_q, out_status_d;
  logic [31:0]                out_addr_q, out_addr_d;

  logic [asa_pkg::LANES-1:0]  row_used;
  asa_pkg::chk_t              chk;
  asa_pkg::bm_wr_t            bm_wr;
  logic                       size_ok;
  logic                       last_row;
  logic                       done;
  logic                       out_load;
  logic                       in_acc;

  asa_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_row_i  (row_q),
    .rd_data_o (row_used),
    .wr_i      (bm_wr)
  );

  asa_row_check u_row_check (
    .row_i  (row_q),
    .used_i (row_used),
    .size_i (size_q),
    .chk_o  (chk)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == asa_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign size_ok       = (size_q == asa_pkg::SZ_ONE) || (size_q == asa_pkg::SZ_TWO) ||
                         (size_q == asa_pkg::SZ_FOUR);
  assign last_row      = (row_q == asa_pkg::ROW_W'(asa_pkg::ROWS - 1));
  assign done          = !size_ok || chk.hit || last_row;
  assign out_load      = (state_q == asa_pkg::S_SCAN) && done &&
                         (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    size_d       = size_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    bm_wr        = '0;
    case (state_q)
      asa_pkg::S_IDLE: begin
        if (in_acc) begin
          size_d  = s_axis_tdata[2:0];
          row_d   = '0;
          state_d = asa_pkg::S_SCAN;
        end
      end
      asa_pkg::S_SCAN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = asa_pkg::S_IDLE;
          if (!size_ok) begin
            out_status_d = asa_pkg::ST_BAD_SIZE;
            out_addr_d   = '0;
          end else if (chk.hit) begin
            out_status_d = asa_pkg::ST_GRANTED;
            out_addr_d   = base_q + 32'({row_q, chk.lane});
            bm_wr        = '{en: 1'b1, row: row_q, mask: chk.set_mask};
          end else begin
            out_status_d = asa_pkg::ST_FULL;
            out_addr_d   = '0;
          end
        end else if (!done) begin
          row_d = row_q + 1'b1;
        end
      end
      default: begin
        state_d = asa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asa_pkg::S_IDLE;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

  `ASSERT_CLK(a_accept_starts_scan, in_acc |=> (state_q == asa_pkg::S_SCAN), "accept did not start scan")
  `ASSERT_CLK(a_write_on_grant, bm_wr.en |-> (out_load && size_ok && chk.hit), "bitmap written without grant")
  `ASSERT_CLK(a_zero_addr_no_grant, (m_axis_tvalid && (m_axis_tuser != 2'(asa_pkg::ST_GRANTED))) |-> (m_axis_tdata == 32'd0), "non-grant result carries an address")
  `ASSERT_CLK(a_load_ends_scan, out_load |=> (state_q == asa_pkg::S_IDLE) && m_axis_tvalid, "result load did not end scan")

endmodule

[tb/aligned_slot_allocator_test.sv]
// Self-checking testbench for the aligned slot allocator: directed and random requests.
`timescale 1ns / 1ps

module aligned_slot_allocator_test;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TARGET_REQUESTS = 750;

  typedef struct packed {
    asa_pkg::status_e status;
    logic [31:0]      addr;
  } slot_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [2:0] request_size
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] slot_address
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  aligned_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the block state
  logic [asa_pkg::REGION_BYTES-1:0] used_bytes = '0;
  logic [31:0]                      base_shadow = '0;

  slot_result_t awaited_slots[$];

  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;
  int errors        = 0;
  int requests_sent = 0;
  int n_granted     = 0;
  int n_bad_size    = 0;
  int n_full        = 0;
  int n_base_writes = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic slot_result_t allocate_slot(input logic [2:0] size);
    slot_result_t res;
    int unsigned  len;
    int unsigned  off;
    bit           fits;
    bit           done;
    res.status = asa_pkg::ST_BAD_SIZE;
    res.addr   = '0;
    len        = size;
    done       = 1'b0;
    if (size == asa_pkg::SZ_ONE || size == asa_pkg::SZ_TWO || size == asa_pkg::SZ_FOUR) begin
      res.status = asa_pkg::ST_FULL;
      off = 0;
      while (!done && off + len <= asa_pkg::REGION_BYTES) begin
        fits = 1'b1;
        for (int unsigned k = 0; k < len; k++) begin
          if (used_bytes[off + k]) fits = 1'b0;
        end
        if (fits) begin
          for (int unsigned k = 0; k < len; k++) used_bytes[off + k] = 1'b1;
          res.status = asa_pkg::ST_GRANTED;
          res.addr   = base_shadow + 32'(off);
          done       = 1'b1;
        end
        off += len;
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] pick_valid_size();
    case ($urandom_range(0, 2))
      0: return asa_pkg::SZ_ONE;
      1: return asa_pkg::SZ_TWO;
      default: return asa_pkg::SZ_FOUR;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_request(input logic [2:0] size);
    slot_result_t res;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = allocate_slot(size);
    awaited_slots.push_back(res);
    requests_sent++;
    case (res.status)
      asa_pkg::ST_GRANTED:  n_granted++;
      asa_pkg::ST_BAD_SIZE: n_bad_size++;
      default:              n_full++;
    endcase
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (awaited_slots.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_region_base(input logic [31:0] value);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    base_shadow = value;
    n_base_writes++;
  endtask

  // result beats, with random backpressure bursts
  always @(posedge clk_i) begin
    static int ready_hold = 0;
    slot_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_slots.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata, 32'h0);
      end else begin
        want = awaited_slots.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata !== want.addr)
          report_mismatch("slot_address", m_axis_tdata, want.addr);
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    static int stall_cycles = 0;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, awaited_slots.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // base is 0 out of reset; checks first-fit packing of mixed sizes
  task automatic test_default_base();
    send_request(asa_pkg::SZ_ONE);
    send_request(asa_pkg::SZ_TWO);
    send_request(asa_pkg::SZ_ONE);
    send_request(asa_pkg::SZ_FOUR);
  endtask

  task automatic test_invalid_sizes();
    send_request(3'd0);
    send_request(3'd3);
    send_request(3'd5);
    send_request(3'd6);
    send_request(3'd7);
  endtask

  task automatic test_address_wrap();
    write_region_base(32'hFFFF_FFFF);
    send_request(asa_pkg::SZ_ONE);
    send_request(asa_pkg::SZ_FOUR);
    send_request(asa_pkg::SZ_TWO);
    send_request(asa_pkg::SZ_ONE);
    write_region_base(32'hFFFF_FFF8);
    send_request(asa_pkg::SZ_FOUR);
    send_request(asa_pkg::SZ_TWO);
    send_request(asa_pkg::SZ_FOUR);
  endtask

  // mostly legal sizes until the whole region is used
  task automatic test_fill_region();
    int n;
    n = 0;
    write_region_base($urandom());
    while (used_bytes != '1) begin
      if ($urandom_range(0, 9) == 0) send_request(3'($urandom_range(0, 7)));
      else send_request(pick_valid_size());
      n++;
      if (n == 12) write_region_base($urandom());
      if (n == 20) wait_results_drained();
    end
  endtask

  task automatic test_region_full();
    send_request(asa_pkg::SZ_FOUR);
    send_request(asa_pkg::SZ_TWO);
    send_request(asa_pkg::SZ_ONE);
    send_request(3'd7);
  endtask

  task automatic test_random_stream();
    int phase;
    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      case (phase % 3)
        0: write_region_base(32'h0);
        1: write_region_base(32'hFFFF_FFFF);
        default: write_region_base($urandom());
      endcase
      if (requests_sent + 120 >= TARGET_REQUESTS) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      repeat (100) begin
        if ($urandom_range(0, 1) == 0) send_request(pick_valid_size());
        else send_request(3'($urandom_range(0, 7)));
      end
      phase++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_base();
    test_invalid_sizes();
    test_address_wrap();
    test_fill_region();
    test_region_full();
    test_random_stream();
    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (awaited_slots.size() != 0) begin
      report_mismatch("results left over", 32'(awaited_slots.size()), 32'h0);
    end
    $display("Sent %0d requests: %0d granted, %0d bad size, %0d region full.",
             requests_sent, n_granted, n_bad_size, n_full);
    $display("Region base written %0d times, wrap and both extremes included.", n_base_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
